FILE: sv/sweep_and_prune_broadphase_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sweep-and-prune broad phase
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SWEEP_AND_PRUNE_BROADPHASE_TOP_MACROS_SVH
`define SWEEP_AND_PRUNE_BROADPHASE_TOP_MACROS_SVH

// same-cycle implication
`define SAPB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAPB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sapb_pkg.sv
// ---------------------------------------------------------------------------
// sapb_pkg
// Shared codes and controller/datapath command and status types.
// ---------------------------------------------------------------------------
package sapb_pkg;

  localparam int OBJ_AW = 10;
  localparam int EP_AW  = 13;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_SWEEP  = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;

  typedef enum logic [2:0] {
    WS_RD,
    WS_CUR,
    WS_LO,
    WS_HI,
    WS_UPD
  } ep_wsel_e;

  typedef struct packed {
    logic              in_ld;
    logic [1:0]        axis;
    logic              ep_re;
    logic [EP_AW-1:0]  ep_raddr;
    logic              ep_we;
    logic [EP_AW-1:0]  ep_waddr;
    ep_wsel_e          ep_wsel;
    logic              cur_ld;
    logic              box_re;
    logic [OBJ_AW-1:0] box_raddr;
    logic              box_we;
    logic              boxa_ld;
    logic              boxa_in;
    logic              row_re;
    logic [OBJ_AW-1:0] row_raddr;
    logic              row_we;
    logic [OBJ_AW-1:0] row_waddr;
    logic [OBJ_AW-1:0] row_bit;
    logic              row_val;
    logic              row_clr;
  } sapb_cmd_t;

  typedef struct packed {
    logic              rd_gt_hi;
    logic              rd_gt_lo;
    logic              cur_lt_rd;
    logic              rd_upper;
    logic              cur_upper;
    logic [OBJ_AW-1:0] rd_owner;
    logic [OBJ_AW-1:0] cur_owner;
    logic              touch;
    logic              row_bit;
  } sapb_sts_t;

endpackage

FILE: sv/sapb_datapath.sv
// ---------------------------------------------------------------------------
// sapb_datapath
// Endpoint lists, box store, pair matrix rows and the compare logic.
// ---------------------------------------------------------------------------
module sapb_datapath #(
  parameter int MAX_OBJECTS = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic                clk_i,
  input  logic [5:0]          object_id_i,
  input  logic signed [31:0]  min_x_i,
  input  logic signed [31:0]  min_y_i,
  input  logic signed [31:0]  min_z_i,
  input  logic signed [31:0]  max_x_i,
  input  logic signed [31:0]  max_y_i,
  input  logic signed [31:0]  max_z_i,
  input  sapb_pkg::sapb_cmd_t cmd_i,
  output sapb_pkg::sapb_sts_t sts_o
);
  import sapb_pkg::*;

  localparam int LIST_LEN = 2 * MAX_OBJECTS;
  localparam int EP_DEPTH = 3 * LIST_LEN;
  localparam int EAW      = $clog2(EP_DEPTH);
  localparam int OW       = $clog2(MAX_OBJECTS);
  localparam int CW       = COORD_BITS;

  typedef logic [5:0][CW-1:0] box_t;

  box_t                   in_box_q;
  box_t                   boxa_q;
  box_t                   box_rd_q;
  logic [OW-1:0]          in_id_q;

  logic [CW-1:0]          ep_val_mem [EP_DEPTH];
  logic [OW-1:0]          ep_own_mem [EP_DEPTH];
  logic                   ep_up_mem  [EP_DEPTH];
  box_t                   box_mem    [MAX_OBJECTS];
  logic [MAX_OBJECTS-1:0] row_mem    [MAX_OBJECTS];

  logic [CW-1:0]          rd_val_q, cur_val_q;
  logic [OW-1:0]          rd_own_q, cur_own_q;
  logic                   rd_up_q, cur_up_q;
  logic [MAX_OBJECTS-1:0] row_rd_q;

  logic [CW-1:0]          wval;
  logic [OW-1:0]          wown;
  logic                   wup;
  logic [MAX_OBJECTS-1:0] row_wdata;
  logic [2:0]             lsel, hsel;
  logic [2:0]             ax_ok;

  assign lsel = {1'b0, cmd_i.axis};
  assign hsel = {1'b0, cmd_i.axis} + 3'd3;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) begin
      in_box_q[0] <= CW'(min_x_i);
      in_box_q[1] <= CW'(min_y_i);
      in_box_q[2] <= CW'(min_z_i);
      in_box_q[3] <= CW'(max_x_i);
      in_box_q[4] <= CW'(max_y_i);
      in_box_q[5] <= CW'(max_z_i);
      in_id_q     <= OW'(object_id_i);
    end
  end

  always_comb begin
    wval = rd_val_q;
    wown = rd_own_q;
    wup  = rd_up_q;
    case (cmd_i.ep_wsel)
      WS_RD: begin
      end
      WS_CUR: begin
        wval = cur_val_q;
        wown = cur_own_q;
        wup  = cur_up_q;
      end
      WS_LO: begin
        wval = in_box_q[lsel];
        wown = in_id_q;
        wup  = 1'b0;
      end
      WS_HI: begin
        wval = in_box_q[hsel];
        wown = in_id_q;
        wup  = 1'b1;
      end
      WS_UPD: begin
        wval = rd_up_q ? in_box_q[hsel] : in_box_q[lsel];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ep_we) begin
      ep_val_mem[cmd_i.ep_waddr[EAW-1:0]] <= wval;
      ep_own_mem[cmd_i.ep_waddr[EAW-1:0]] <= wown;
      ep_up_mem[cmd_i.ep_waddr[EAW-1:0]]  <= wup;
    end
    if (cmd_i.ep_re) begin
      rd_val_q <= ep_val_mem[cmd_i.ep_raddr[EAW-1:0]];
      rd_own_q <= ep_own_mem[cmd_i.ep_raddr[EAW-1:0]];
      rd_up_q  <= ep_up_mem[cmd_i.ep_raddr[EAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_ld) begin
      cur_val_q <= rd_val_q;
      cur_own_q <= rd_own_q;
      cur_up_q  <= rd_up_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_we) begin
      box_mem[in_id_q] <= in_box_q;
    end
    if (cmd_i.box_re) begin
      box_rd_q <= box_mem[cmd_i.box_raddr[OW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.boxa_ld) begin
      boxa_q <= cmd_i.boxa_in ? in_box_q : box_rd_q;
    end
  end

  always_comb begin
    row_wdata = row_rd_q;
    row_wdata[cmd_i.row_bit[OW-1:0]] = cmd_i.row_val;
    if (cmd_i.row_clr) begin
      row_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_we) begin
      row_mem[cmd_i.row_waddr[OW-1:0]] <= row_wdata;
    end
    if (cmd_i.row_re) begin
      row_rd_q <= row_mem[cmd_i.row_raddr[OW-1:0]];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ax_ok[a] = ($signed(boxa_q[a]) <= $signed(box_rd_q[a+3])) &&
                 ($signed(box_rd_q[a]) <= $signed(boxa_q[a+3]));
    end
  end

  always_comb begin
    sts_o.rd_gt_hi  = $signed(rd_val_q) > $signed(in_box_q[hsel]);
    sts_o.rd_gt_lo  = $signed(rd_val_q) > $signed(in_box_q[lsel]);
    sts_o.cur_lt_rd = $signed(cur_val_q) < $signed(rd_val_q);
    sts_o.rd_upper  = rd_up_q;
    sts_o.cur_upper = cur_up_q;
    sts_o.rd_owner  = OBJ_AW'(rd_own_q);
    sts_o.cur_owner = OBJ_AW'(cur_own_q);
    sts_o.touch     = &ax_ok;
    sts_o.row_bit   = row_rd_q[cmd_i.row_bit[OW-1:0]];
  end

endmodule

FILE: sv/sapb_ctrl.sv
// ---------------------------------------------------------------------------
// sapb_ctrl
// Sequencer for add, update, remove, sweep and query; owns presence bits,
// counters and the result register.
// ---------------------------------------------------------------------------
module sapb_ctrl #(
  parameter int MAX_OBJECTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic [5:0]          object_id_i,
  input  logic [5:0]          other_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic                pair_present_o,
  output logic [11:0]         pairs_added_o,
  output logic [11:0]         pairs_removed_o,
  output sapb_pkg::sapb_cmd_t cmd_o,
  input  sapb_pkg::sapb_sts_t sts_i
);
  import sapb_pkg::*;

  localparam int LIST_LEN = 2 * MAX_OBJECTS;
  localparam int OW       = $clog2(MAX_OBJECTS);
  localparam int KW       = $clog2(MAX_OBJECTS + 1);
  localparam int PW       = $clog2(LIST_LEN + 1);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_A_INIT  = 5'd2;
  localparam logic [4:0] S_A_RD    = 5'd3;
  localparam logic [4:0] S_A_EV    = 5'd4;
  localparam logic [4:0] S_A_LO    = 5'd5;
  localparam logic [4:0] S_A_HI    = 5'd6;
  localparam logic [4:0] S_A_PAIRK = 5'd7;
  localparam logic [4:0] S_U_RD    = 5'd8;
  localparam logic [4:0] S_U_EV    = 5'd9;
  localparam logic [4:0] S_R_PAIRK = 5'd10;
  localparam logic [4:0] S_R_RD    = 5'd11;
  localparam logic [4:0] S_R_EV    = 5'd12;
  localparam logic [4:0] S_S_T     = 5'd13;
  localparam logic [4:0] S_S_LD    = 5'd14;
  localparam logic [4:0] S_S_BOX   = 5'd15;
  localparam logic [4:0] S_S_RD    = 5'd16;
  localparam logic [4:0] S_S_EV    = 5'd17;
  localparam logic [4:0] S_S_PL    = 5'd18;
  localparam logic [4:0] S_P_RD    = 5'd19;
  localparam logic [4:0] S_P_EVA   = 5'd20;
  localparam logic [4:0] S_P_EVB   = 5'd21;
  localparam logic [4:0] S_Q_RD    = 5'd22;
  localparam logic [4:0] S_Q_EV    = 5'd23;
  localparam logic [4:0] S_DONE    = 5'd24;

  logic [4:0]             state_q, state_d, ret_q, ret_d;
  logic [1:0]             axis_q, axis_d;
  logic [PW-1:0]          j_q, j_d, i_q, i_d, w_q, w_d, phi_q, phi_d, plo_q, plo_d;
  logic                   phase_q, phase_d, pmark_q, pmark_d;
  logic [KW-1:0]          k_q, k_d, nlive_q, nlive_d;
  logic [MAX_OBJECTS-1:0] live_q, live_d;
  logic [OW-1:0]          id_q, id_d, oth_q, oth_d, pa_q, pa_d, pb_q, pb_d;
  logic [11:0]            cadd_q, cadd_d, cdel_q, cdel_d;
  logic [1:0]             st_q, st_d;
  logic                   pres_q, pres_d;
  logic                   ov_q, ov_d;
  logic [1:0]             ost_q, ost_d;
  logic                   opres_q, opres_d;
  logic [11:0]            oadd_q, oadd_d, odel_q, odel_d;

  logic [PW-1:0]          n;
  logic [OW-1:0]          in_id, in_oth, rd_own, cur_own;
  logic                   id_bad, oth_bad, act;

  function automatic logic [EP_AW-1:0] ep_addr(input logic [1:0] ax, input logic [PW-1:0] pos);
    logic [EP_AW-1:0] base;
    base = (ax == 2'd2) ? EP_AW'(2 * LIST_LEN) : ((ax == 2'd1) ? EP_AW'(LIST_LEN) : '0);
    return base + EP_AW'(pos);
  endfunction

  function automatic logic [11:0] sat_inc(input logic [11:0] c);
    return (c == 12'hFFF) ? c : c + 12'd1;
  endfunction

  assign n       = PW'({nlive_q, 1'b0});
  assign in_id   = OW'(object_id_i);
  assign in_oth  = OW'(other_id_i);
  assign rd_own  = sts_i.rd_owner[OW-1:0];
  assign cur_own = sts_i.cur_owner[OW-1:0];
  assign id_bad  = 32'(object_id_i) >= MAX_OBJECTS;
  assign oth_bad = 32'(other_id_i) >= MAX_OBJECTS;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    axis_d  = axis_q;
    j_d     = j_q;
    i_d     = i_q;
    w_d     = w_q;
    phi_d   = phi_q;
    plo_d   = plo_q;
    phase_d = phase_q;
    pmark_d = pmark_q;
    k_d     = k_q;
    nlive_d = nlive_q;
    live_d  = live_q;
    id_d    = id_q;
    oth_d   = oth_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    cadd_d  = cadd_q;
    cdel_d  = cdel_q;
    st_d    = st_q;
    pres_d  = pres_q;
    ov_d    = ov_q;
    ost_d   = ost_q;
    opres_d = opres_q;
    oadd_d  = oadd_q;
    odel_d  = odel_q;
    act     = 1'b0;
    cmd_o      = '0;
    cmd_o.axis = axis_q;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        cmd_o.row_we    = 1'b1;
        cmd_o.row_clr   = 1'b1;
        cmd_o.row_waddr = OBJ_AW'(k_q);
        k_d = k_q + KW'(1);
        if (k_q == KW'(MAX_OBJECTS - 1)) begin
          k_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_ld = 1'b1;
          id_d   = in_id;
          oth_d  = in_oth;
          cadd_d = '0;
          cdel_d = '0;
          st_d   = ST_OK;
          pres_d = 1'b0;
          axis_d = '0;
          j_d    = '0;
          w_d    = '0;
          k_d    = '0;
          state_d = S_DONE;
          unique case (op_i)
            OP_ADD: begin
              if (id_bad) begin
                st_d = ST_ABSENT;
              end else if (live_q[in_id] || nlive_q == KW'(MAX_OBJECTS)) begin
                st_d = ST_DUP;
              end else begin
                state_d = S_A_INIT;
              end
            end
            OP_UPDATE: begin
              if (id_bad || !live_q[in_id]) begin
                st_d = ST_ABSENT;
              end else begin
                state_d = S_U_RD;
              end
            end
            OP_REMOVE: begin
              if (id_bad || !live_q[in_id]) begin
                st_d = ST_ABSENT;
              end else begin
                state_d = S_R_PAIRK;
              end
            end
            OP_SWEEP: begin
              j_d     = PW'(1);
              state_d = S_S_T;
            end
            OP_QUERY: begin
              if (id_bad || oth_bad || !live_q[in_id] || !live_q[in_oth]) begin
                st_d = ST_ABSENT;
              end else begin
                state_d = S_Q_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_A_INIT: begin
        cmd_o.box_we  = 1'b1;
        cmd_o.boxa_ld = 1'b1;
        cmd_o.boxa_in = 1'b1;
        j_d     = n;
        phase_d = 1'b0;
        state_d = S_A_RD;
      end
      S_A_RD: begin
        if (j_q == '0) begin
          plo_d = '0;
          if (!phase_q) begin
            phi_d = '0;
          end
          state_d = S_A_LO;
        end else begin
          cmd_o.ep_re    = 1'b1;
          cmd_o.ep_raddr = ep_addr(axis_q, j_q - PW'(1));
          state_d = S_A_EV;
        end
      end
      S_A_EV: begin
        if (!phase_q && sts_i.rd_gt_hi) begin
          cmd_o.ep_we    = 1'b1;
          cmd_o.ep_waddr = ep_addr(axis_q, j_q + PW'(1));
          cmd_o.ep_wsel  = WS_RD;
          j_d     = j_q - PW'(1);
          state_d = S_A_RD;
        end else begin
          if (!phase_q) begin
            phi_d = j_q;
          end
          phase_d = 1'b1;
          if (sts_i.rd_gt_lo) begin
            cmd_o.ep_we    = 1'b1;
            cmd_o.ep_waddr = ep_addr(axis_q, j_q);
            cmd_o.ep_wsel  = WS_RD;
            j_d     = j_q - PW'(1);
            state_d = S_A_RD;
          end else begin
            plo_d   = j_q;
            state_d = S_A_LO;
          end
        end
      end
      S_A_LO: begin
        cmd_o.ep_we    = 1'b1;
        cmd_o.ep_waddr = ep_addr(axis_q, plo_q);
        cmd_o.ep_wsel  = WS_LO;
        state_d = S_A_HI;
      end
      S_A_HI: begin
        cmd_o.ep_we    = 1'b1;
        cmd_o.ep_waddr = ep_addr(axis_q, phi_q + PW'(1));
        cmd_o.ep_wsel  = WS_HI;
        if (axis_q == 2'd2) begin
          live_d[id_q] = 1'b1;
          nlive_d = nlive_q + KW'(1);
          k_d     = '0;
          state_d = S_A_PAIRK;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_A_INIT;
        end
      end
      S_A_PAIRK: begin
        if (k_q == KW'(MAX_OBJECTS)) begin
          state_d = S_DONE;
        end else begin
          k_d = k_q + KW'(1);
          if (k_q[OW-1:0] != id_q && live_q[k_q[OW-1:0]]) begin
            pa_d    = id_q;
            pb_d    = k_q[OW-1:0];
            pmark_d = 1'b1;
            ret_d   = S_A_PAIRK;
            state_d = S_P_RD;
          end
        end
      end
      S_U_RD: begin
        cmd_o.box_we = 1'b1;
        if (j_q == n) begin
          j_d = '0;
          if (axis_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          cmd_o.ep_re    = 1'b1;
          cmd_o.ep_raddr = ep_addr(axis_q, j_q);
          state_d = S_U_EV;
        end
      end
      S_U_EV: begin
        if (rd_own == id_q) begin
          cmd_o.ep_we    = 1'b1;
          cmd_o.ep_waddr = ep_addr(axis_q, j_q);
          cmd_o.ep_wsel  = WS_UPD;
        end
        j_d     = j_q + PW'(1);
        state_d = S_U_RD;
      end
      S_R_PAIRK: begin
        if (k_q == KW'(MAX_OBJECTS)) begin
          j_d     = '0;
          w_d     = '0;
          axis_d  = '0;
          state_d = S_R_RD;
        end else begin
          k_d     = k_q + KW'(1);
          pa_d    = id_q;
          pb_d    = k_q[OW-1:0];
          pmark_d = 1'b0;
          ret_d   = S_R_PAIRK;
          state_d = S_P_RD;
        end
      end
      S_R_RD: begin
        if (j_q == n) begin
          j_d = '0;
          w_d = '0;
          if (axis_q == 2'd2) begin
            live_d[id_q] = 1'b0;
            nlive_d = nlive_q - KW'(1);
            state_d = S_DONE;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          cmd_o.ep_re    = 1'b1;
          cmd_o.ep_raddr = ep_addr(axis_q, j_q);
          state_d = S_R_EV;
        end
      end
      S_R_EV: begin
        if (rd_own != id_q) begin
          if (j_q != w_q) begin
            cmd_o.ep_we    = 1'b1;
            cmd_o.ep_waddr = ep_addr(axis_q, w_q);
            cmd_o.ep_wsel  = WS_RD;
          end
          w_d = w_q + PW'(1);
        end
        j_d     = j_q + PW'(1);
        state_d = S_R_RD;
      end
      S_S_T: begin
        if (j_q >= n) begin
          j_d = PW'(1);
          if (axis_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          cmd_o.ep_re    = 1'b1;
          cmd_o.ep_raddr = ep_addr(axis_q, j_q);
          state_d = S_S_LD;
        end
      end
      S_S_LD: begin
        cmd_o.cur_ld    = 1'b1;
        cmd_o.box_re    = 1'b1;
        cmd_o.box_raddr = sts_i.rd_owner;
        i_d     = j_q;
        state_d = S_S_BOX;
      end
      S_S_BOX: begin
        cmd_o.boxa_ld = 1'b1;
        state_d = S_S_RD;
      end
      S_S_RD: begin
        if (i_q == '0) begin
          state_d = S_S_PL;
        end else begin
          cmd_o.ep_re    = 1'b1;
          cmd_o.ep_raddr = ep_addr(axis_q, i_q - PW'(1));
          state_d = S_S_EV;
        end
      end
      S_S_EV: begin
        if (sts_i.cur_lt_rd) begin
          cmd_o.ep_we    = 1'b1;
          cmd_o.ep_waddr = ep_addr(axis_q, i_q);
          cmd_o.ep_wsel  = WS_RD;
          i_d   = i_q - PW'(1);
          pa_d  = cur_own;
          pb_d  = rd_own;
          ret_d = S_S_RD;
          if (!sts_i.cur_upper && sts_i.rd_upper) begin
            pmark_d = 1'b1;
            state_d = S_P_RD;
          end else if (sts_i.cur_upper && !sts_i.rd_upper) begin
            pmark_d = 1'b0;
            state_d = S_P_RD;
          end else begin
            state_d = S_S_RD;
          end
        end else begin
          state_d = S_S_PL;
        end
      end
      S_S_PL: begin
        cmd_o.ep_we    = 1'b1;
        cmd_o.ep_waddr = ep_addr(axis_q, i_q);
        cmd_o.ep_wsel  = WS_CUR;
        j_d     = j_q + PW'(1);
        state_d = S_S_T;
      end
      S_P_RD: begin
        cmd_o.row_re    = 1'b1;
        cmd_o.row_raddr = OBJ_AW'(pa_q);
        cmd_o.box_re    = 1'b1;
        cmd_o.box_raddr = OBJ_AW'(pb_q);
        state_d = S_P_EVA;
      end
      S_P_EVA: begin
        cmd_o.row_bit = OBJ_AW'(pb_q);
        act = (pa_q != pb_q) &&
              (pmark_q ? (sts_i.touch && !sts_i.row_bit) : sts_i.row_bit);
        if (act) begin
          cmd_o.row_we    = 1'b1;
          cmd_o.row_waddr = OBJ_AW'(pa_q);
          cmd_o.row_val   = pmark_q;
          cmd_o.row_re    = 1'b1;
          cmd_o.row_raddr = OBJ_AW'(pb_q);
          state_d = S_P_EVB;
        end else begin
          state_d = ret_q;
        end
      end
      S_P_EVB: begin
        cmd_o.row_bit   = OBJ_AW'(pa_q);
        cmd_o.row_we    = 1'b1;
        cmd_o.row_waddr = OBJ_AW'(pb_q);
        cmd_o.row_val   = pmark_q;
        if (pmark_q) begin
          cadd_d = sat_inc(cadd_q);
        end else begin
          cdel_d = sat_inc(cdel_q);
        end
        state_d = ret_q;
      end
      S_Q_RD: begin
        cmd_o.row_re    = 1'b1;
        cmd_o.row_raddr = OBJ_AW'(id_q);
        state_d = S_Q_EV;
      end
      S_Q_EV: begin
        cmd_o.row_bit = OBJ_AW'(oth_q);
        pres_d  = (id_q != oth_q) && sts_i.row_bit;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          opres_d = pres_q;
          oadd_d  = cadd_q;
          odel_d  = cdel_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= S_IDLE;
      axis_q  <= '0;
      j_q     <= '0;
      i_q     <= '0;
      w_q     <= '0;
      phi_q   <= '0;
      plo_q   <= '0;
      phase_q <= 1'b0;
      pmark_q <= 1'b0;
      k_q     <= '0;
      nlive_q <= '0;
      live_q  <= '0;
      id_q    <= '0;
      oth_q   <= '0;
      pa_q    <= '0;
      pb_q    <= '0;
      cadd_q  <= '0;
      cdel_q  <= '0;
      st_q    <= ST_OK;
      pres_q  <= 1'b0;
      ov_q    <= 1'b0;
      ost_q   <= ST_OK;
      opres_q <= 1'b0;
      oadd_q  <= '0;
      odel_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      axis_q  <= axis_d;
      j_q     <= j_d;
      i_q     <= i_d;
      w_q     <= w_d;
      phi_q   <= phi_d;
      plo_q   <= plo_d;
      phase_q <= phase_d;
      pmark_q <= pmark_d;
      k_q     <= k_d;
      nlive_q <= nlive_d;
      live_q  <= live_d;
      id_q    <= id_d;
      oth_q   <= oth_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      cadd_q  <= cadd_d;
      cdel_q  <= cdel_d;
      st_q    <= st_d;
      pres_q  <= pres_d;
      ov_q    <= ov_d;
      ost_q   <= ost_d;
      opres_q <= opres_d;
      oadd_q  <= oadd_d;
      odel_q  <= odel_d;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign pair_present_o  = opres_q;
  assign pairs_added_o   = oadd_q;
  assign pairs_removed_o = odel_q;

endmodule

FILE: sv/sweep_and_prune_broadphase_top.sv
// ---------------------------------------------------------------------------
// sweep_and_prune_broadphase_top
// Broad-phase pair finder: sorted endpoint lists per axis and a pair matrix.
// ---------------------------------------------------------------------------
// Operations: query reads one pair-matrix row; update rewrites the endpoints
//   of the object on every axis; add inserts into each sorted list and tests
//   the new object against every live one; remove clears its pairs and compacts
//   each list; sweep insertion-sorts each list and tests pairs on swaps.
// Throughput: one item at a time; next item accepted once the result is loaded.
// Reset: pair rows cleared one per cycle, all MAX_OBJECTS rows, input stalled.
`include "sweep_and_prune_broadphase_top_macros.svh"

module sweep_and_prune_broadphase_top #(
  parameter int MAX_OBJECTS = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [5:0]         object_id_i,
  input  logic [5:0]         other_id_i,
  input  logic signed [31:0] min_x_i,
  input  logic signed [31:0] min_y_i,
  input  logic signed [31:0] min_z_i,
  input  logic signed [31:0] max_x_i,
  input  logic signed [31:0] max_y_i,
  input  logic signed [31:0] max_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic               pair_present_o,
  output logic [11:0]        pairs_added_o,
  output logic [11:0]        pairs_removed_o
);
  import sapb_pkg::*;

  sapb_cmd_t cmd;
  sapb_sts_t sts;

  sapb_ctrl #(
    .MAX_OBJECTS(MAX_OBJECTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .object_id_i    (object_id_i),
    .other_id_i     (other_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .pair_present_o (pair_present_o),
    .pairs_added_o  (pairs_added_o),
    .pairs_removed_o(pairs_removed_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  sapb_datapath #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .object_id_i(object_id_i),
    .min_x_i    (min_x_i),
    .min_y_i    (min_y_i),
    .min_z_i    (min_z_i),
    .max_x_i    (max_x_i),
    .max_y_i    (max_y_i),
    .max_z_i    (max_z_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  `SAPB_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after item")
  `SAPB_ASSERT_IMP(a_status_code, out_valid_o, status_o == ST_OK || status_o == ST_ABSENT || status_o == ST_DUP, "bad status code")
  `SAPB_ASSERT_IMP(a_error_fields_zero, out_valid_o && status_o != ST_OK, !pair_present_o && pairs_added_o == 12'd0 && pairs_removed_o == 12'd0, "error item carries data")

endmodule
